// File: sv/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg: shared types and constants for the masked Pearson correlator
// Field widths, result status codes and the status bundle of the
// ratio/root unit.
// ----------------------------------------------------------------------------
package mpc_pkg;

  // fixed field widths of the channel words
  localparam int SAMPLE_W = 16;
  localparam int CORR_W   = 16;
  localparam int COUNT_W  = 13;

  // digit width of the shared multiplier (one digit per cycle)
  localparam int DIG_W = 16;

  // width of the rounded ratio magnitude (0 .. 32768)
  localparam int Q_W = 16;

  // largest positive Q1.15 value
  localparam logic [CORR_W-1:0] Q15_MAX = 16'h7FFF;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PAIRS = 2'd1,
    ST_ZERO_VAR = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // status of the ratio/root unit
  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage

// File: sv/mpc_if.sv
// ----------------------------------------------------------------------------
// mpc_if: channel interfaces of the masked Pearson correlator
// Sample pair channel and result channel, each with valid/ready and payload.
// ----------------------------------------------------------------------------

// sample pair channel
interface mpc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [mpc_pkg::SAMPLE_W-1:0] x_sample;
  logic signed [mpc_pkg::SAMPLE_W-1:0] y_sample;
  logic                                x_present;
  logic                                y_present;
  logic                                last_pair;

  modport source (
    output valid, x_sample, y_sample, x_present, y_present, last_pair,
    input  ready
  );
  modport sink (
    input  valid, x_sample, y_sample, x_present, y_present, last_pair,
    output ready
  );
endinterface

// result channel
interface mpc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mpc_pkg::CORR_W-1:0]  correlation;
  mpc_pkg::status_t                   status;
  logic [mpc_pkg::COUNT_W-1:0]        pair_count;

  modport source (
    output valid, correlation, status, pair_count,
    input  ready
  );
  modport sink (
    input  valid, correlation, status, pair_count,
    output ready
  );
endinterface

// File: sv/mpc_root.sv
// ----------------------------------------------------------------------------
// mpc_root: rounded ratio of a value to a square root
// Finds the largest m with (2m-1)^2 * p <= nsq * 2^32, one bit of m at a time,
// top bit first, using only fixed shifts, adds and one compare on a wide residual.
// ----------------------------------------------------------------------------
module mpc_root #(
  parameter int PW = 114
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [PW-1:0]             p,
  input  logic [PW-1:0]             nsq,
  output mpc_pkg::root_stat_t       stat,
  output logic [mpc_pkg::Q_W-1:0]   q
);

  localparam int QW    = mpc_pkg::Q_W;
  localparam int PS_SH = 2 * QW;
  localparam int BS_SH = QW + 1;
  localparam int RW    = PW + PS_SH + 4;
  localparam int KW    = $clog2(QW);

  // residual, scaled cross term, scaled p, trial step
  logic signed [RW-1:0] r;
  logic signed [RW-1:0] bs;
  logic signed [RW-1:0] ps;
  logic signed [RW-1:0] dd;
  logic signed [RW-1:0] diff;
  logic [KW-1:0]        k;
  logic                 ph;
  logic                 busy;
  logic                 done;
  logic                 take;

  // trial compare
  assign diff = r - dd;
  assign take = !diff[RW-1];

  assign stat.busy = busy;
  assign stat.done = done;

  // bit recurrence: phase 0 forms the step, phase 1 tests and updates
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        r    <= {{(RW - PW - PS_SH){1'b0}}, nsq, {PS_SH{1'b0}}} - RW'(p);
        ps   <= {{(RW - PW - PS_SH){1'b0}}, p, {PS_SH{1'b0}}};
        bs   <= -RW'({p, {BS_SH{1'b0}}});
        q    <= '0;
        k    <= KW'(QW - 1);
        ph   <= 1'b0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!ph) begin
          dd <= bs + ps;
          ph <= 1'b1;
        end else begin
          ph <= 1'b0;
          if (take) begin
            r    <= diff;
            q[k] <= 1'b1;
            bs   <= (bs + (ps <<< 1)) >>> 1;
          end else begin
            bs <= bs >>> 1;
          end
          ps <= ps >>> 2;
          if (k == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            k <= k - 1'b1;
          end
        end
      end
    end
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("root unit done while still busy");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("root unit started while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && !done)
    else $error("root unit did not go busy after start");

endmodule

// File: sv/masked_pearson_correlation.sv
// ----------------------------------------------------------------------------
// masked_pearson_correlation: Pearson coefficient of masked sample pairs
// Accumulates exact sums over pairs with both samples present and, on the
// last pair of a set, emits r in Q1.15 with a status and the pair count.
// ----------------------------------------------------------------------------
// Pairs: a counted pair passes through accept, three products on the shared
//   multiplier and the update; an uncounted pair is only accepted. No pair
//   is taken while one is in work or a result waits to be sent. A last pair
//   runs up to eight ND-digit products and the 16-bit rounding root search;
//   overflow or no pairs skips both, a zero variance the last two and root.
// Reset: synchronous rst clears the sums, count, sequencer and output valid.
// ----------------------------------------------------------------------------
module masked_pearson_correlation #(
  parameter int MAX_PAIRS   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  mpc_in_if.sink    samples,
  mpc_out_if.source result
);

  localparam int SW  = (SAMPLE_BITS < mpc_pkg::SAMPLE_W) ? SAMPLE_BITS : mpc_pkg::SAMPLE_W;
  localparam int CW  = $clog2(MAX_PAIRS + 1);
  localparam int S1W = SW + CW;
  localparam int S2W = 2 * SW + CW;
  localparam int VW  = 2 * SW + 2 * CW - 1;
  localparam int DW  = mpc_pkg::DIG_W;
  localparam int ND  = (VW + DW - 1) / DW;
  localparam int BW  = ND * DW;
  localparam int AW  = 2 * VW;
  localparam int DXW = $clog2(ND);
  localparam int PRW = VW + DW + 1;
  localparam int QW  = mpc_pkg::Q_W;
  localparam int OW  = mpc_pkg::CORR_W;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MXX    = 10'b0000000010,
    S_MYY    = 10'b0000000100,
    S_MXY    = 10'b0000001000,
    S_ADD    = 10'b0000010000,
    S_CHECK  = 10'b0000100000,
    S_FMUL   = 10'b0001000000,
    S_FSTORE = 10'b0010000000,
    S_ROOT   = 10'b0100000000,
    S_SEND   = 10'b1000000000
  } state_t;

  // products of the final evaluation, in order
  typedef enum logic [2:0] {
    JOB_N_SXX    = 3'd0,
    JOB_SX_SX    = 3'd1,
    JOB_N_SYY    = 3'd2,
    JOB_SY_SY    = 3'd3,
    JOB_N_SXY    = 3'd4,
    JOB_SX_SY    = 3'd5,
    JOB_VAR_PROD = 3'd6,
    JOB_COV_SQ   = 3'd7
  } job_t;

  state_t state;
  job_t   job;

  logic signed [SW-1:0]  x_in;
  logic signed [SW-1:0]  y_in;
  logic signed [SW-1:0]  x_s;
  logic signed [SW-1:0]  y_s;
  logic                  last_q;
  logic signed [S1W-1:0] sum_x;
  logic signed [S1W-1:0] sum_y;
  logic signed [S2W-1:0] sum_xx;
  logic signed [S2W-1:0] sum_yy;
  logic signed [S2W-1:0] sum_xy;
  logic [CW-1:0]         count;
  logic                  ovf;

  logic signed [AW-1:0]  acc;
  logic signed [AW-1:0]  acc_next;
  logic signed [AW-1:0]  prod_ext;
  logic [DXW-1:0]        didx;
  logic [DXW-1:0]        dtop;
  logic signed [VW-1:0]  mul_a;
  logic signed [BW-1:0]  mul_b;
  logic [DW-1:0]         dig;
  logic signed [DW:0]    dig_ext;
  logic signed [PRW-1:0] prod;
  logic                  mul_on;

  logic signed [VW-1:0]  t_reg;
  logic signed [VW-1:0]  va;
  logic signed [VW-1:0]  vb;
  logic signed [VW-1:0]  nu;
  logic [AW-1:0]         p_reg;

  logic                  root_start;
  mpc_pkg::root_stat_t   root_st;
  logic [QW-1:0]         root_q;

  logic signed [OW-1:0]        corr_q;
  logic signed [OW-1:0]        corr_val;
  mpc_pkg::status_t            st_q;
  logic                        out_valid_q;
  logic signed [OW-1:0]        out_corr;
  mpc_pkg::status_t            out_st;
  logic [mpc_pkg::COUNT_W-1:0] out_cnt;

  logic accept;
  logic both;
  logic full;
  logic out_free;
  logic load;

  // input word handshake and sample narrowing
  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign x_in          = samples.x_sample[SW-1:0];
  assign y_in          = samples.y_sample[SW-1:0];
  assign both          = samples.x_present && samples.y_present;
  assign full          = (count == CW'(MAX_PAIRS));

  // output register handshake
  assign out_free = !out_valid_q || result.ready;
  assign load     = (state == S_SEND) && out_free;

  // shared multiplier: one digit of b per cycle, top digit first and signed
  assign mul_on   = (state == S_MXX) || (state == S_MYY) || (state == S_MXY) ||
                    (state == S_FMUL);
  assign dtop     = (state == S_FMUL) ? DXW'(ND - 1) : '0;
  assign dig      = mul_b[DW*didx +: DW];
  assign dig_ext  = (didx == dtop) ? {dig[DW-1], dig} : {1'b0, dig};
  assign prod     = mul_a * dig_ext;
  assign prod_ext = AW'(prod);
  assign acc_next = ((didx == dtop) ? '0 : (acc <<< DW)) + prod_ext;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MXX: begin
        mul_a = VW'(x_s);
        mul_b = BW'(x_s);
      end
      S_MYY: begin
        mul_a = VW'(y_s);
        mul_b = BW'(y_s);
      end
      S_MXY: begin
        mul_a = VW'(x_s);
        mul_b = BW'(y_s);
      end
      S_FMUL: begin
        case (job)
          JOB_N_SXX: begin
            mul_a = VW'(count);
            mul_b = BW'(sum_xx);
          end
          JOB_SX_SX: begin
            mul_a = VW'(sum_x);
            mul_b = BW'(sum_x);
          end
          JOB_N_SYY: begin
            mul_a = VW'(count);
            mul_b = BW'(sum_yy);
          end
          JOB_SY_SY: begin
            mul_a = VW'(sum_y);
            mul_b = BW'(sum_y);
          end
          JOB_N_SXY: begin
            mul_a = VW'(count);
            mul_b = BW'(sum_xy);
          end
          JOB_SX_SY: begin
            mul_a = VW'(sum_x);
            mul_b = BW'(sum_y);
          end
          JOB_VAR_PROD: begin
            mul_a = va;
            mul_b = BW'(vb);
          end
          JOB_COV_SQ: begin
            mul_a = nu;
            mul_b = BW'(nu);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // product accumulator
  always_ff @(posedge clk) begin
    if (mul_on) begin
      acc <= acc_next;
    end
  end

  // sign and saturation of the rounded ratio
  always_comb begin
    if (nu[VW-1]) begin
      corr_val = OW'(0) - OW'(root_q);
    end else if (root_q[QW-1]) begin
      corr_val = mpc_pkg::Q15_MAX;
    end else begin
      corr_val = OW'(root_q);
    end
  end

  assign root_start = (state == S_FSTORE) && (job == JOB_COV_SQ);

  mpc_root #(
    .PW (AW)
  ) u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .p     (p_reg),
    .nsq   (acc),
    .stat  (root_st),
    .q     (root_q)
  );

  // sequencer and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      job    <= JOB_N_SXX;
      didx   <= '0;
      sum_x  <= '0;
      sum_y  <= '0;
      sum_xx <= '0;
      sum_yy <= '0;
      sum_xy <= '0;
      count  <= '0;
      ovf    <= 1'b0;
      st_q   <= mpc_pkg::ST_OK;
      corr_q <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          didx <= '0;
          if (accept) begin
            x_s    <= x_in;
            y_s    <= y_in;
            last_q <= samples.last_pair;
            if (both && !full) begin
              state <= S_MXX;
            end else begin
              if (both) begin
                ovf <= 1'b1;
              end
              state <= samples.last_pair ? S_CHECK : S_IDLE;
            end
          end
        end
        S_MXX: begin
          state <= S_MYY;
        end
        S_MYY: begin
          sum_xx <= sum_xx + acc[S2W-1:0];
          state  <= S_MXY;
        end
        S_MXY: begin
          sum_yy <= sum_yy + acc[S2W-1:0];
          state  <= S_ADD;
        end
        S_ADD: begin
          sum_xy <= sum_xy + acc[S2W-1:0];
          sum_x  <= sum_x + S1W'(x_s);
          sum_y  <= sum_y + S1W'(y_s);
          count  <= count + 1'b1;
          state  <= last_q ? S_CHECK : S_IDLE;
        end
        S_CHECK: begin
          corr_q <= '0;
          job    <= JOB_N_SXX;
          didx   <= DXW'(ND - 1);
          if (ovf) begin
            st_q  <= mpc_pkg::ST_OVERFLOW;
            state <= S_SEND;
          end else if (count == '0) begin
            st_q  <= mpc_pkg::ST_NO_PAIRS;
            state <= S_SEND;
          end else begin
            st_q  <= mpc_pkg::ST_OK;
            state <= S_FMUL;
          end
        end
        S_FMUL: begin
          if (didx == '0) begin
            state <= S_FSTORE;
          end else begin
            didx <= didx - 1'b1;
          end
        end
        S_FSTORE: begin
          didx  <= DXW'(ND - 1);
          job   <= job_t'(job + 1'b1);
          state <= S_FMUL;
          case (job)
            JOB_N_SXX, JOB_N_SYY, JOB_N_SXY: begin
              t_reg <= acc[VW-1:0];
            end
            JOB_SX_SX: begin
              va <= t_reg - acc[VW-1:0];
            end
            JOB_SY_SY: begin
              vb <= t_reg - acc[VW-1:0];
            end
            JOB_SX_SY: begin
              nu <= t_reg - acc[VW-1:0];
              if (va == '0 || vb == '0) begin
                st_q  <= mpc_pkg::ST_ZERO_VAR;
                state <= S_SEND;
              end
            end
            JOB_VAR_PROD: begin
              p_reg <= acc;
            end
            JOB_COV_SQ: begin
              state <= S_ROOT;
            end
            default: ;
          endcase
        end
        S_ROOT: begin
          if (root_st.done) begin
            corr_q <= corr_val;
            state  <= S_SEND;
          end
        end
        S_SEND: begin
          if (out_free) begin
            sum_x  <= '0;
            sum_y  <= '0;
            sum_xx <= '0;
            sum_yy <= '0;
            sum_xy <= '0;
            count  <= '0;
            ovf    <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (result.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_corr <= corr_q;
      out_st   <= st_q;
      out_cnt  <= mpc_pkg::COUNT_W'(count);
    end
  end

  assign result.valid       = out_valid_q;
  assign result.correlation = out_corr;
  assign result.status      = out_st;
  assign result.pair_count  = out_cnt;

  // checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PAIRS))
    else $error("pair count above capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (load && st_q != mpc_pkg::ST_OK) |-> corr_q == '0)
    else $error("nonzero correlation with error status");

  a_set_clear: assert property (@(posedge clk) disable iff (rst)
    load |=> (count == '0) && !ovf && (sum_x == '0))
    else $error("sums not cleared after result");

  a_root_wait: assert property (@(posedge clk) disable iff (rst)
    root_st.done |-> state == S_ROOT)
    else $error("root unit finished outside its wait state");

  a_root_busy: assert property (@(posedge clk) disable iff (rst)
    root_st.busy |-> state == S_ROOT)
    else $error("root unit busy outside its wait state");

endmodule
